// ===== hdl/vha_pkg.sv =====
`default_nettype none
// ============================================================================
// vha_pkg: shared types and constants for the vector heading block
// Holds the side-band tag that rides along the CORDIC chain and the constant
// function that builds the per-stage arctangent steps in heading units.
// ============================================================================
package vha_pkg;

  localparam real PI = 3.14159265358979323846;
  // Degrees in one radian.
  localparam real DEG_PER_RAD = 180.0 / PI;

  // Per-word side information carried alongside the rotation datapath.
  typedef struct packed {
    logic zero;     // both components are zero
    logic b_zero;   // smaller magnitude is zero, so the octant angle is exactly 0
    logic swap;     // |x| > |y|, so the octant angle is folded from 90 degrees
    logic u_neg;    // the component towards north is negative (y > 0)
    logic v_neg;    // the component towards the left is negative (x > 0)
  } vha_tag_t;

  // atan(2^-idx) expressed in heading units (2^-frac_bits degree) with zf
  // further fraction bits. The first step is exactly 45 degrees.
  function automatic logic [127:0] atan_step(input int idx, input int frac_bits,
                                             input int zf);
    real ang;
    real r;
    real whole_r;
    real part_r;
    logic [63:0] whole;
    logic [63:0] part;
    logic [127:0] res;
    if (idx == 0) begin
      res = 128'(45) << (frac_bits + zf);
    end else begin
      ang     = $atan(2.0 ** (-idx));
      r       = ang * DEG_PER_RAD * (2.0 ** frac_bits);
      whole_r = $floor(r);
      part_r  = (r - whole_r) * (2.0 ** zf);
      whole   = 64'(longint'(whole_r));
      part    = 64'(longint'(part_r));
      res     = (128'(whole) << zf) + 128'(part);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/vha_cordic_stage.sv =====
`default_nettype none
// ============================================================================
// vha_cordic_stage: one registered CORDIC micro-rotation in vectoring mode
// Drives y towards zero by a shift-and-add rotation and accumulates the
// matching arctangent step into the angle register.
// ============================================================================
module vha_cordic_stage #(
  parameter int XW        = 76,
  parameter int ZW        = 64,
  parameter int SHIFT     = 0,
  parameter int FRAC_BITS = 6,
  parameter int ZF        = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  vha_pkg::vha_tag_t        in_tag,
  input  logic signed [XW-1:0]     in_x,
  input  logic signed [XW-1:0]     in_y,
  input  logic signed [ZW-1:0]     in_z,
  output logic                     out_valid,
  output vha_pkg::vha_tag_t        out_tag,
  output logic signed [XW-1:0]     out_x,
  output logic signed [XW-1:0]     out_y,
  output logic signed [ZW-1:0]     out_z
);
  import vha_pkg::*;

  localparam logic signed [ZW-1:0] STEP = ZW'(atan_step(SHIFT, FRAC_BITS, ZF));

  logic signed [XW-1:0] x_sh;
  logic signed [XW-1:0] y_sh;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;

  assign x_sh = in_x >>> SHIFT;
  assign y_sh = in_y >>> SHIFT;

  // Rotate clockwise while y is non-negative, anticlockwise otherwise.
  always_comb begin
    if (!in_y[XW-1]) begin
      x_next = in_x + y_sh;
      y_next = in_y - x_sh;
      z_next = in_z + STEP;
    end else begin
      x_next = in_x - y_sh;
      y_next = in_y + x_sh;
      z_next = in_z - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_tag <= in_tag;
    out_x   <= x_next;
    out_y   <= y_next;
    out_z   <= z_next;
  end

endmodule
`default_nettype wire

// ===== hdl/vector_heading_angle.sv =====
`default_nettype none
// Pipeline: an accepted word passes the input register, stages 1 and 2, the CORDIC chain,
// both unfold stages and the output register; done marks its result for a single cycle.
// Throughput: one word per cycle; start is taken whenever busy is low.
// The CORDIC chain does one micro-rotation per register stage.
// Reset: rst (synchronous) clears every valid bit; busy is high in reset and drops after it.
// ============================================================================
// vector_heading_angle: heading of a screen vector measured from north
// Folds the vector into the first octant, measures the octant angle with a
// fully pipelined CORDIC in vectoring mode, unfolds it to a full turn and
// rounds it to the nearest 2^-ANGLE_FRAC_BITS degree.
// ============================================================================
module vector_heading_angle #(
  parameter int COORD_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [COORD_WIDTH-1:0]   vec_x,
  input  logic signed [COORD_WIDTH-1:0]   vec_y,
  output logic                            done,
  output logic [ANGLE_FRAC_BITS+8:0]      heading,
  output logic                            zero_vector
);
  import vha_pkg::*;

  // Sizing. The heading needs nine integer bits of degrees on top of its
  // fraction. The chain length and the guard bits are chosen so that the
  // total angle error sits many orders of magnitude below half a unit, which
  // keeps the round-to-nearest decision exact away from pathological ties.
  localparam int CW    = COORD_WIDTH;
  localparam int HW    = ANGLE_FRAC_BITS + 9;
  localparam int ITERS = 48 + ANGLE_FRAC_BITS;
  localparam int FB    = ITERS + 4;
  localparam int XW    = CW + 2 + FB;
  localparam int ZF    = 42 + ANGLE_FRAC_BITS;
  localparam int ZW    = HW + ZF + 1;
  localparam int LAT   = ITERS + 6;

  localparam logic [ZW-1:0] QUARTER_Z = ZW'(90) << (ANGLE_FRAC_BITS + ZF);
  localparam logic [ZW-1:0] HALF_Z    = ZW'(180) << (ANGLE_FRAC_BITS + ZF);
  localparam logic [ZW-1:0] FULL_Z    = ZW'(360) << (ANGLE_FRAC_BITS + ZF);
  localparam logic [ZW-1:0] ROUND_Z   = ZW'(1) << (ZF - 1);
  localparam logic [HW:0]   FULL_UNITS = (HW + 1)'(360) << ANGLE_FRAC_BITS;

  // --------------------------------------------------------------------------
  // Input register. The receiver can never stall, so busy only covers reset.
  // --------------------------------------------------------------------------
  logic                  accept;
  logic                  s0_valid;
  logic signed [CW-1:0]  s0_x;
  logic signed [CW-1:0]  s0_y;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      s0_valid <= 1'b0;
    end else begin
      busy     <= 1'b0;
      s0_valid <= accept;
    end
    s0_x <= vec_x;
    s0_y <= vec_y;
  end

  // --------------------------------------------------------------------------
  // Stage 1: magnitudes and quadrant. North is (0,-1), so the northward
  // component is -y and the leftward one is -x; their magnitudes are |y|
  // and |x|. The most negative code gives its exact magnitude as unsigned.
  // --------------------------------------------------------------------------
  logic          s1_valid;
  logic [CW-1:0] s1_ax;
  logic [CW-1:0] s1_ay;
  logic          s1_u_neg;
  logic          s1_v_neg;
  logic          s1_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
    s1_ax    <= s0_x[CW-1] ? CW'(-s0_x) : CW'(s0_x);
    s1_ay    <= s0_y[CW-1] ? CW'(-s0_y) : CW'(s0_y);
    s1_u_neg <= !s0_y[CW-1] && (s0_y != '0);
    s1_v_neg <= !s0_x[CW-1] && (s0_x != '0);
    s1_zero  <= (s0_x == '0) && (s0_y == '0);
  end

  // --------------------------------------------------------------------------
  // Stage 2: octant fold. The larger magnitude becomes x and the smaller y,
  // so the CORDIC only ever sees angles between 0 and 45 degrees.
  // --------------------------------------------------------------------------
  logic          swap;
  logic [CW-1:0] oct_a;
  logic [CW-1:0] oct_b;

  assign swap  = s1_ax > s1_ay;
  assign oct_a = swap ? s1_ax : s1_ay;
  assign oct_b = swap ? s1_ay : s1_ax;

  logic                  s2_valid;
  vha_tag_t              s2_tag;
  logic signed [XW-1:0]  s2_x;
  logic signed [XW-1:0]  s2_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_tag.zero   <= s1_zero;
    s2_tag.b_zero <= (oct_b == '0);
    s2_tag.swap   <= swap;
    s2_tag.u_neg  <= s1_u_neg;
    s2_tag.v_neg  <= s1_v_neg;
    s2_x          <= $signed({2'b00, oct_a, {FB{1'b0}}});
    s2_y          <= $signed({2'b00, oct_b, {FB{1'b0}}});
  end

  // --------------------------------------------------------------------------
  // CORDIC chain: one micro-rotation per stage, shift k at stage k.
  // --------------------------------------------------------------------------
  logic                  c_valid [ITERS+1];
  vha_tag_t              c_tag   [ITERS+1];
  logic signed [XW-1:0]  c_x     [ITERS+1];
  logic signed [XW-1:0]  c_y     [ITERS+1];
  logic signed [ZW-1:0]  c_z     [ITERS+1];

  assign c_valid[0] = s2_valid;
  assign c_tag[0]   = s2_tag;
  assign c_x[0]     = s2_x;
  assign c_y[0]     = s2_y;
  assign c_z[0]     = '0;

  for (genvar k = 0; k < ITERS; k++) begin : g_cordic
    vha_cordic_stage #(
      .XW        (XW),
      .ZW        (ZW),
      .SHIFT     (k),
      .FRAC_BITS (ANGLE_FRAC_BITS),
      .ZF        (ZF)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[k]),
      .in_tag    (c_tag[k]),
      .in_x      (c_x[k]),
      .in_y      (c_y[k]),
      .in_z      (c_z[k]),
      .out_valid (c_valid[k+1]),
      .out_tag   (c_tag[k+1]),
      .out_x     (c_x[k+1]),
      .out_y     (c_y[k+1]),
      .out_z     (c_z[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Unfold stage 1: undo the octant swap. When the smaller magnitude is zero
  // the angle is exactly zero, so axis directions come out as exact
  // multiples of 90 degrees instead of carrying the CORDIC residue.
  // --------------------------------------------------------------------------
  logic [ZW-1:0] oct_angle;
  logic [ZW-1:0] th_next;
  logic          f1_valid;
  vha_tag_t      f1_tag;
  logic [ZW-1:0] f1_th;

  assign oct_angle = c_tag[ITERS].b_zero ? '0 : ZW'(unsigned'(c_z[ITERS]));
  assign th_next   = c_tag[ITERS].swap ? (QUARTER_Z - oct_angle) : oct_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= c_valid[ITERS];
    end
    f1_tag <= c_tag[ITERS];
    f1_th  <= th_next;
  end

  // --------------------------------------------------------------------------
  // Unfold stage 2: place the angle in its quadrant. Turning left from north
  // takes the angle as it is; the southern half mirrors about 180 degrees,
  // and the northern right-hand quarter is measured back from a full turn.
  // --------------------------------------------------------------------------
  logic [ZW-1:0] turn_next;
  logic          f2_valid;
  logic          f2_zero;
  logic [ZW-1:0] f2_turn;

  always_comb begin
    case ({f1_tag.u_neg, f1_tag.v_neg})
      2'b00:   turn_next = f1_th;
      2'b10:   turn_next = HALF_Z - f1_th;
      2'b11:   turn_next = HALF_Z + f1_th;
      default: turn_next = FULL_Z - f1_th;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else begin
      f2_valid <= f1_valid;
    end
    f2_zero <= f1_tag.zero;
    f2_turn <= turn_next;
  end

  // --------------------------------------------------------------------------
  // Output stage: round half up to whole units and keep a heading that
  // rounds up to a full turn one unit short of it.
  // --------------------------------------------------------------------------
  logic [ZW-1:0] rounded;
  logic [HW:0]   units;
  logic [HW-1:0] heading_next;

  assign rounded = f2_turn + ROUND_Z;
  assign units   = rounded[ZF +: HW+1];

  always_comb begin
    if (f2_zero) begin
      heading_next = '0;
    end else if (units >= FULL_UNITS) begin
      heading_next = HW'(FULL_UNITS - (HW + 1)'(1));
    end else begin
      heading_next = units[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f2_valid;
    end
    heading     <= heading_next;
    zero_vector <= f2_zero;
  end

`ifndef NO_ASSERTIONS
  // Once out of reset the block never refuses a word.
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy)
    else $error("busy raised outside reset");

  // Every accepted word produces its result after the fixed pipeline delay.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted word produced no result on time");

  // No result appears that was not caused by an accepted word.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a matching accepted word");

  // A delivered heading is always below one full turn.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((HW + 1)'(heading) < FULL_UNITS))
    else $error("heading reached a full turn");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_vector_heading_angle.sv =====
`default_nettype none
// ============================================================================
// tb_vector_heading_angle: self-checking bench for the vector heading block
// Feeds screen vectors through the start/busy command port. A short table of
// axis, extreme and near-full-circle words comes first, then about 800 random
// words. Every word that is accepted gets an expected heading, either typed
// into the table or worked out by a bit-exact predictor of the series
// arithmetic. Each done strobe is then compared with the oldest expectation.
// ============================================================================
module tb_vector_heading_angle;

  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 6;
  localparam int HEAD_W    = FRAC_BITS + 9;
  localparam int UNITS_DEG = 1 << FRAC_BITS;
  localparam logic [63:0] FULL_UNITS = 64'(360) << FRAC_BITS;
  localparam logic [63:0] TOP_UNIT   = FULL_UNITS - 64'd1;
  // 1/(2*pi) truncated to an unsigned Q0.64 fraction.
  localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;
  localparam logic [63:0] QUARTER    = 64'h4000000000000000;
  localparam logic [63:0] HALF       = 64'h8000000000000000;
  // Pipeline depth of the block from acceptance to done.
  localparam int LATENCY     = 53 + FRAC_BITS;
  localparam int RANDOM_WORDS = 800;
  // The last stretch of the random part runs with no idling at all.
  localparam int QUIET_WORDS  = 150;
  localparam int REPORT_CAP   = 200;

  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic              zero_vector;
  } heading_word_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    bit                        fixed_answer;
    logic [HEAD_W-1:0]         heading;
    logic                      zero_vector;
  } vector_row_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic signed [COORD_W-1:0]  vec_x;
  logic signed [COORD_W-1:0]  vec_y;
  logic                       done;
  logic [HEAD_W-1:0]          heading;
  logic                       zero_vector;

  // Side-band of the word currently on the inputs: when fixed_now is set the
  // expectation comes from the table rather than from the predictor.
  bit                         fixed_now;
  heading_word_t              fixed_word;

  heading_word_t              pending_headings[$];
  int                         fail_count;
  int                         reported;

  vector_heading_angle #(
    .COORD_WIDTH     (COORD_W),
    .ANGLE_FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .vec_x       (vec_x),
    .vec_y       (vec_y),
    .done        (done),
    .heading     (heading),
    .zero_vector (zero_vector)
  );

  // Directed words. Axis directions land on exact multiples of 90 degrees,
  // a vector a hair right of north rounds up to a full turn and saturates,
  // and one a hair left of north rounds down to 0. Diagonals and odd angles
  // are left to the predictor.
  vector_row_t directed_rows [22] = '{
    '{16'sd0,      16'sd0,      1'b1, HEAD_W'(0),              1'b1},
    '{16'sd0,      -16'sd1,     1'b1, HEAD_W'(0),              1'b0},
    '{16'sd0,      16'sh8000,   1'b1, HEAD_W'(0),              1'b0},
    '{-16'sd1,     16'sd0,      1'b1, HEAD_W'(90 * UNITS_DEG),  1'b0},
    '{16'sh8000,   16'sd0,      1'b1, HEAD_W'(90 * UNITS_DEG),  1'b0},
    '{16'sd0,      16'sd1,      1'b1, HEAD_W'(180 * UNITS_DEG), 1'b0},
    '{16'sd0,      16'sd32767,  1'b1, HEAD_W'(180 * UNITS_DEG), 1'b0},
    '{16'sd1,      16'sd0,      1'b1, HEAD_W'(270 * UNITS_DEG), 1'b0},
    '{16'sd32767,  16'sd0,      1'b1, HEAD_W'(270 * UNITS_DEG), 1'b0},
    '{16'sd1,      16'sh8000,   1'b1, HEAD_W'(TOP_UNIT),        1'b0},
    '{16'sd1,      -16'sd32767, 1'b1, HEAD_W'(TOP_UNIT),        1'b0},
    '{-16'sd1,     16'sh8000,   1'b1, HEAD_W'(0),              1'b0},
    '{16'sh8000,   16'sh8000,   1'b0, HEAD_W'(0),              1'b0},
    '{16'sd32767,  16'sd32767,  1'b0, HEAD_W'(0),              1'b0},
    '{16'sh8000,   16'sd32767,  1'b0, HEAD_W'(0),              1'b0},
    '{16'sd32767,  16'sh8000,   1'b0, HEAD_W'(0),              1'b0},
    '{-16'sd1,     -16'sd1,     1'b0, HEAD_W'(0),              1'b0},
    '{16'sd1,      16'sd1,      1'b0, HEAD_W'(0),              1'b0},
    '{16'sh8000,   -16'sd32767, 1'b0, HEAD_W'(0),              1'b0},
    '{16'sd12345,  -16'sd23456, 1'b0, HEAD_W'(0),              1'b0},
    '{-16'sd3,     16'sd4,      1'b0, HEAD_W'(0),              1'b0},
    '{16'sh7FFF,   16'sh5555,   1'b0, HEAD_W'(0),              1'b0}
  };

  // floor(num * 2^64 / den) for num < den; the quotient fits in 64 bits.
  function automatic logic [63:0] fraction_q64(input logic [63:0] num,
                                               input logic [63:0] den);
    logic [127:0] quot;
    quot = {num, 64'd0} / {64'd0, den};
    return quot[63:0];
  endfunction

  // atan(b/a) as a Q0.64 fraction of a turn, for a >= b >= 0 and a > 0.
  // The series is atan = sum over n of y * z^n * (2^n n!)^2 / (2n+1)!, with
  // y = ab/(a^2+b^2) and z = b^2/(a^2+b^2); each term is built from the last
  // by a truncated product and a truncated subtraction of term/(2n+1).
  function automatic logic [63:0] octant_turn(input logic [63:0] a,
                                              input logic [63:0] b);
    logic [63:0]  den;
    logic [63:0]  ratio;
    logic [63:0]  ratio_sq;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] prod;
    int           n;
    if (b == 64'd0) begin
      return 64'd0;
    end
    den      = a * a + b * b;
    ratio    = fraction_q64(a * b, den);
    ratio_sq = fraction_q64(b * b, den);
    term     = ratio;
    sum      = ratio;
    for (n = 1; n <= 100 && term != 64'd0; n++) begin
      prod = 128'(term) * 128'(ratio_sq);
      term = prod[127:64];
      term = term - term / 64'(2 * n + 1);
      sum  = sum + term;
    end
    prod = 128'(sum) * 128'(INV_TWO_PI);
    return prod[127:64];
  endfunction

  // Expected heading of one screen vector. North is (0,-1), so the angle is
  // measured on u = -y (towards north) and v = -x (towards the left).
  function automatic heading_word_t predict_heading(
      input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y);
    heading_word_t res;
    longint        u;
    longint        v;
    logic [63:0]   au;
    logic [63:0]   av;
    logic [63:0]   th;
    logic [63:0]   turn;
    logic [63:0]   units;
    logic [127:0]  prod;
    u  = -longint'(y);
    v  = -longint'(x);
    au = (u < 0) ? 64'(-u) : 64'(u);
    av = (v < 0) ? 64'(-v) : 64'(v);
    res.heading     = '0;
    res.zero_vector = 1'b1;
    if (au == 64'd0 && av == 64'd0) begin
      return res;
    end
    if (av <= au) begin
      th = octant_turn(au, av);
    end else begin
      th = QUARTER - octant_turn(av, au);
    end
    // Unfold the first-quadrant angle into the full turn.
    if (u >= 0 && v >= 0) begin
      turn = th;
    end else if (u < 0 && v >= 0) begin
      turn = HALF - th;
    end else if (u < 0) begin
      turn = HALF + th;
    end else begin
      turn = 64'd0 - th;
    end
    // Scale to heading units and round half up on the top fraction bit.
    prod  = 128'(turn) * 128'(FULL_UNITS);
    units = prod[127:64] + 64'(prod[63]);
    if (units >= FULL_UNITS) begin
      units = TOP_UNIT;
    end
    res.heading     = units[HEAD_W-1:0];
    res.zero_vector = 1'b0;
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous guard: even with every word idling for the longest burst, the run ends
  // well before the timeout.
  initial begin
    #(12 * 400000);
    $display("CHECKS FAILED");
    $finish;
  end

  // Scoreboard. Both the acceptance and the result strobe are sampled at the
  // rising edge, before the block's own registers move.
  always @(posedge clk) begin
    heading_word_t want;
    if (!rst) begin
      if (start && !busy) begin
        if (fixed_now) begin
          pending_headings.push_back(fixed_word);
        end else begin
          pending_headings.push_back(predict_heading(vec_x, vec_y));
        end
      end
      if (done) begin
        if (pending_headings.size() == 0) begin
          fail_count++;
          if (reported < REPORT_CAP) begin
            $display("%0t: result with nothing expected, heading %0d zero_vector %b",
                     $time, heading, zero_vector);
            reported++;
          end
        end else begin
          want = pending_headings.pop_front();
          if (heading !== want.heading) begin
            fail_count++;
            if (reported < REPORT_CAP) begin
              $display("%0t: heading mismatch, expected %0d, actual %0d",
                       $time, want.heading, heading);
              reported++;
            end
          end
          if (zero_vector !== want.zero_vector) begin
            fail_count++;
            if (reported < REPORT_CAP) begin
              $display("%0t: zero_vector mismatch, expected %b, actual %b",
                       $time, want.zero_vector, zero_vector);
              reported++;
            end
          end
        end
      end
    end
  end

  // Offers one word on the falling edge and holds it until the block takes
  // it. When idle is set, one word in six first drops start for a random burst;
  // otherwise start stays high straight into the next word.
  task automatic send_word(input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input bit fixed, input heading_word_t answer,
                           input bit idle);
    @(negedge clk);
    if (idle && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    start      <= 1'b1;
    vec_x      <= x;
    vec_y      <= y;
    fixed_now  <= fixed;
    fixed_word <= answer;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  initial begin
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    int                        span;
    int                        i;
    heading_word_t             none;
    none       = '0;
    fail_count = 0;
    reported   = 0;
    rst        = 1'b1;
    start      = 1'b0;
    vec_x      = '0;
    vec_y      = '0;
    fixed_now  = 1'b0;
    fixed_word = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].x, directed_rows[r].y, directed_rows[r].fixed_answer,
                '{directed_rows[r].heading, directed_rows[r].zero_vector}, 1'b1);
    end

    // Random words, mixed across full-range vectors, short vectors (where
    // truncation in the series matters most), vectors hugging an axis or a
    // diagonal, and the extreme component values.
    for (i = 0; i < RANDOM_WORDS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          rx = COORD_W'($urandom);
          ry = COORD_W'($urandom);
        end
        4: begin
          rx = COORD_W'($urandom_range(0, 16) - 8);
          ry = COORD_W'($urandom_range(0, 16) - 8);
        end
        5: begin
          if ($urandom_range(0, 1) == 0) begin
            rx = COORD_W'($urandom);
            ry = COORD_W'($urandom_range(0, 4) - 2);
          end else begin
            rx = COORD_W'($urandom_range(0, 4) - 2);
            ry = COORD_W'($urandom);
          end
        end
        6: begin
          span = $urandom_range(1, 32767);
          rx   = COORD_W'(span);
          ry   = COORD_W'(span + $urandom_range(0, 4) - 2);
          if ($urandom_range(0, 1) == 0) rx = -rx;
          if ($urandom_range(0, 1) == 0) ry = -ry;
        end
        7: begin
          case ($urandom_range(0, 5))
            0: rx = 16'sh8000;
            1: rx = 16'sh8001;
            2: rx = 16'sh7FFF;
            3: rx = -16'sd1;
            4: rx = 16'sd1;
            default: rx = 16'sd0;
          endcase
          case ($urandom_range(0, 5))
            0: ry = 16'sh8000;
            1: ry = 16'sh8001;
            2: ry = 16'sh7FFF;
            3: ry = -16'sd1;
            4: ry = 16'sd1;
            default: ry = 16'sd0;
          endcase
        end
        default: begin
          rx = COORD_W'($urandom_range(0, 2000) - 1000);
          ry = COORD_W'($urandom_range(0, 2000) - 1000);
        end
      endcase
      send_word(rx, ry, 1'b0, none, i < RANDOM_WORDS - QUIET_WORDS);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
    // A little beyond the pipeline depth, so that a stray strobe is caught.
    repeat (LATENCY + 20) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== vector_heading_angle.f =====
hdl/vha_pkg.sv
hdl/vha_cordic_stage.sv
hdl/vector_heading_angle.sv
tb/sv/tb_vector_heading_angle.sv
